/* src/ezr_pkg.sv */
// ----------------------------------------------------------------------------
// ezr_pkg: shared types and constants for the zyx euler rotation matrix
// cordic arctangent table, datapath widths and the fixed-point helpers
// ----------------------------------------------------------------------------
package ezr_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int FRAC_BITS    = 14;
  localparam int OUT_BITS     = 16;
  localparam int CORDIC_STEPS = 30;
  localparam int DW           = 34;  // q2.30 plus guard bits for the cordic
  localparam int ZW           = 33;
  localparam int SHIFT_BITS   = 5;
  localparam int CW           = 34;  // width of a product result held in q2.30
  localparam int SW           = 36;  // width of a sum of two products

  localparam logic signed [DW-1:0] CORDIC_GAIN = DW'(652032874);

  function automatic logic signed [ZW-1:0] atan_turn(input logic [SHIFT_BITS-1:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:  r = ZW'(536870912);
      5'd1:  r = ZW'(316933406);
      5'd2:  r = ZW'(167458907);
      5'd3:  r = ZW'(85004756);
      5'd4:  r = ZW'(42667331);
      5'd5:  r = ZW'(21354465);
      5'd6:  r = ZW'(10679838);
      5'd7:  r = ZW'(5340245);
      5'd8:  r = ZW'(2670163);
      5'd9:  r = ZW'(1335087);
      5'd10: r = ZW'(667544);
      5'd11: r = ZW'(333772);
      5'd12: r = ZW'(166886);
      5'd13: r = ZW'(83443);
      5'd14: r = ZW'(41722);
      5'd15: r = ZW'(20861);
      5'd16: r = ZW'(10430);
      5'd17: r = ZW'(5215);
      5'd18: r = ZW'(2608);
      5'd19: r = ZW'(1304);
      5'd20: r = ZW'(652);
      5'd21: r = ZW'(326);
      5'd22: r = ZW'(163);
      5'd23: r = ZW'(81);
      5'd24: r = ZW'(41);
      5'd25: r = ZW'(20);
      5'd26: r = ZW'(10);
      5'd27: r = ZW'(5);
      5'd28: r = ZW'(3);
      5'd29: r = ZW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // (a*b + 2^29) >>> 30, operands at most about 2^30 in magnitude
  function automatic logic signed [CW-1:0] mul30(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
    logic signed [2*CW-1:0] p;
    p = a * b + (2*CW)'(64'sd1 <<< 29);
    return CW'(p >>> 30);
  endfunction

  function automatic logic signed [OUT_BITS-1:0] finish(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    logic signed [SW-1:0] lim;
    lim = SW'(64'sd1 <<< FRAC_BITS);
    if (30 - FRAC_BITS > 0) r = (v + SW'(64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    else r = v;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return OUT_BITS'(r);
  endfunction

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
  } ezr_rot_t;

  typedef struct packed {
    ezr_rot_t r;
    ezr_rot_t p;
    ezr_rot_t w;
  } ezr_trio_t;

endpackage

/* src/euler_zyx_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// euler_zyx_rotation_matrix: rotation matrix rz*ry*rx from three binary angles
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall with roll_angle, pitch_angle, yaw_angle
// output channel: out_valid / out_stall with m11..m33 in signed q1.14
// one transaction in gives one matrix out, in order
// throughput: one transaction per cycle while out_stall is low
// pipeline: the input register, 30 cordic cells in the chain (one
// micro-rotation each), one stage that undoes the fold and three product
// and rounding stages
// the whole pipeline advances as one; when out_stall is high and a result
// is waiting, every stage holds and in_stall rises
// reset (rst, synchronous) clears only the stage valid bits
// ----------------------------------------------------------------------------
module euler_zyx_rotation_matrix (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] roll_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [15:0] yaw_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] m11,
  output logic signed [15:0] m12,
  output logic signed [15:0] m13,
  output logic signed [15:0] m21,
  output logic signed [15:0] m22,
  output logic signed [15:0] m23,
  output logic signed [15:0] m31,
  output logic signed [15:0] m32,
  output logic signed [15:0] m33
);
  import ezr_pkg::*;

  localparam int LAT = CORDIC_STEPS + 5;

  logic [LAT-1:0] vld;
  logic           en;
  ezr_trio_t      chain [CORDIC_STEPS+1];

  assign en        = !(vld[LAT-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  function automatic ezr_rot_t fold(input logic [15:0] a);
    ezr_rot_t o;
    logic [31:0] u;
    u      = {a[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
    o.flip = u[31] ^ u[30];
    if (o.flip) u[31] = ~u[31];
    o.z = ZW'($signed(u));
    o.x = CORDIC_GAIN;
    o.y = '0;
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      chain[0].r <= fold(roll_angle);
      chain[0].p <= fold(pitch_angle);
      chain[0].w <= fold(yaw_angle);
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    ezr_cell u_cell (
      .clk (clk),
      .en  (en),
      .step(SHIFT_BITS'(g)),
      .din (chain[g]),
      .dout(chain[g+1])
    );
  end

  ezr_matrix u_matrix (
    .clk(clk), .en(en), .din(chain[CORDIC_STEPS]),
    .m11(m11), .m12(m12), .m13(m13),
    .m21(m21), .m22(m22), .m23(m23),
    .m31(m31), .m32(m32), .m33(m33)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid) else $error("stall without pending result");
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(m12) && $stable(m33))
    else $error("stalled result changed");
  a_diag_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> m11 <= 16'sd16384 && m11 >= -16'sd16384)
    else $error("entry outside unit range");
endmodule

/* src/ezr_cell.sv */
// ----------------------------------------------------------------------------
// ezr_cell: one cordic micro-rotation stage for three angles
// shifts by a fixed step index and hands the vectors to the next cell
// ----------------------------------------------------------------------------
module ezr_cell (
  input  logic                     clk,
  input  logic                     en,
  input  logic [4:0]               step,
  input  ezr_pkg::ezr_trio_t       din,
  output ezr_pkg::ezr_trio_t       dout
);
  import ezr_pkg::*;

  function automatic ezr_rot_t rot(input ezr_rot_t a, input logic [SHIFT_BITS-1:0] s);
    ezr_rot_t o;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [ZW-1:0] t;
    dx = a.y >>> s;
    dy = a.x >>> s;
    t  = atan_turn(s);
    o  = a;
    if (!a.z[ZW-1]) begin
      o.x = a.x - dx; o.y = a.y + dy; o.z = a.z - t;
    end else begin
      o.x = a.x + dx; o.y = a.y - dy; o.z = a.z + t;
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      dout.r <= rot(din.r, step);
      dout.p <= rot(din.p, step);
      dout.w <= rot(din.w, step);
    end
  end
endmodule

/* src/ezr_matrix.sv */
// ----------------------------------------------------------------------------
// ezr_matrix: product and rounding pipeline
// a sign stage, two registered multiply levels then rounding and clamping
// ----------------------------------------------------------------------------
module ezr_matrix (
  input  logic                     clk,
  input  logic                     en,
  input  ezr_pkg::ezr_trio_t       din,
  output logic signed [15:0]       m11,
  output logic signed [15:0]       m12,
  output logic signed [15:0]       m13,
  output logic signed [15:0]       m21,
  output logic signed [15:0]       m22,
  output logic signed [15:0]       m23,
  output logic signed [15:0]       m31,
  output logic signed [15:0]       m32,
  output logic signed [15:0]       m33
);
  import ezr_pkg::*;

  logic signed [CW-1:0] sr, cr, sp, cp, sy, cy;
  logic signed [CW-1:0] cysp, sysp, a11, a21, sycr, sysr, cycr, cysr, a32, a33;
  logic signed [CW-1:0] b_sr, b_cr, nsp;
  logic signed [CW-1:0] q12, q13, q22, q23;
  logic signed [CW-1:0] c11, c21, c32, c33, c31, d12, d13, d22, d23;

  // undo the half-turn fold
  always_ff @(posedge clk) begin
    if (en) begin
      sr <= din.r.flip ? -CW'(din.r.y) : CW'(din.r.y);
      cr <= din.r.flip ? -CW'(din.r.x) : CW'(din.r.x);
      sp <= din.p.flip ? -CW'(din.p.y) : CW'(din.p.y);
      cp <= din.p.flip ? -CW'(din.p.x) : CW'(din.p.x);
      sy <= din.w.flip ? -CW'(din.w.y) : CW'(din.w.y);
      cy <= din.w.flip ? -CW'(din.w.x) : CW'(din.w.x);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cysp <= mul30(cy, sp);  sysp <= mul30(sy, sp);
      a11  <= mul30(cy, cp);  a21  <= mul30(sy, cp);
      sycr <= mul30(sy, cr);  sysr <= mul30(sy, sr);
      cycr <= mul30(cy, cr);  cysr <= mul30(cy, sr);
      a32  <= mul30(cp, sr);  a33  <= mul30(cp, cr);
      b_sr <= sr; b_cr <= cr; nsp <= -sp;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q12 <= mul30(cysp, b_sr); q13 <= mul30(cysp, b_cr);
      q22 <= mul30(sysp, b_sr); q23 <= mul30(sysp, b_cr);
      d12 <= sycr; d13 <= sysr; d22 <= cycr; d23 <= cysr;
      c11 <= a11; c21 <= a21; c31 <= nsp; c32 <= a32; c33 <= a33;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m11 <= finish(SW'(c11));
      m12 <= finish(SW'(q12) - SW'(d12));
      m13 <= finish(SW'(q13) + SW'(d13));
      m21 <= finish(SW'(c21));
      m22 <= finish(SW'(q22) + SW'(d22));
      m23 <= finish(SW'(q23) - SW'(d23));
      m31 <= finish(SW'(c31));
      m32 <= finish(SW'(c32));
      m33 <= finish(SW'(c33));
    end
  end
endmodule
